// ===== hw/rtl/srps_pkg.sv =====
// Shared types and constants for the sequence range progression sum unit.
// No dependencies; the other files that use this package refer to it by scoped names.
package srps_pkg;

  // Store geometry
  localparam int MAX_LEN = 1024;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);

  // Field widths fixed by the interface
  localparam int POS_W  = 11;
  localparam int OPER_W = 32;
  localparam int DATA_W = 64;
  localparam int STAT_W = 2;

  // Width used to compare positions against the length
  localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

  typedef enum logic [1:0] {
    REQ_ASSIGN = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_INSERT = 2'd2,
    REQ_QUERY  = 2'd3
  } req_t;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_PLACE = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  // Operation of the shared adder
  typedef enum logic [1:0] {
    DP_IDLE = 2'd0,
    DP_ADD  = 2'd1,
    DP_SUM  = 2'd2
  } dp_op_t;

  // Source of the store write data
  typedef enum logic [1:0] {
    WD_VALUE = 2'd0,
    WD_SUM   = 2'd1,
    WD_COPY  = 2'd2
  } wd_sel_t;

  typedef struct packed {
    logic    init;
    dp_op_t  op;
    wd_sel_t wd_sel;
  } dp_ctrl_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              we;
    logic [ADDR_W-1:0] wr_addr;
  } ram_ctrl_t;

endpackage

// ===== hw/rtl/srps_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module srps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/srps_dp.sv =====
// Datapath: the shared 64-bit adder, progression step and sum accumulator.
// Depends on srps_pkg.
module srps_dp (
  input  logic                               clk,
  input  srps_pkg::dp_ctrl_t                 ctl,
  input  logic signed [srps_pkg::OPER_W-1:0] operand_value,
  input  logic        [srps_pkg::DATA_W-1:0] rd_data,
  output logic        [srps_pkg::DATA_W-1:0] wr_data,
  output logic signed [srps_pkg::DATA_W-1:0] range_sum
);

  logic [srps_pkg::DATA_W-1:0] val;
  logic [srps_pkg::DATA_W-1:0] step;
  logic [srps_pkg::DATA_W-1:0] acc;
  logic [srps_pkg::DATA_W-1:0] add_a;
  logic [srps_pkg::DATA_W-1:0] add_out;
  logic [srps_pkg::DATA_W-1:0] ext_val;

  assign ext_val = srps_pkg::DATA_W'(operand_value);

  // Shared adder: element plus step, or accumulator plus element
  assign add_a   = (ctl.op == srps_pkg::DP_SUM) ? acc : step;
  assign add_out = add_a + rd_data;

  // Select write data
  always_comb begin
    case (ctl.wd_sel)
      srps_pkg::WD_SUM:  wr_data = add_out;
      srps_pkg::WD_COPY: wr_data = rd_data;
      default:           wr_data = val;
    endcase
  end

  // Load operands on a new transfer, then advance step or accumulate
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      val  <= ext_val;
      step <= ext_val;
      acc  <= '0;
    end else begin
      if (ctl.op == srps_pkg::DP_ADD) begin
        step <= step + val;
      end
      if (ctl.op == srps_pkg::DP_SUM) begin
        acc <= add_out;
      end
    end
  end

  assign range_sum = acc;

endmodule

// ===== hw/rtl/srps_ctrl.sv =====
// Sequencer: request checks, sequence length, and the element walk over the store.
// Depends on srps_pkg.
module srps_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  srps_pkg::req_t                   req,
  input  logic [srps_pkg::POS_W-1:0]       first_position,
  input  logic [srps_pkg::POS_W-1:0]       last_position,
  input  logic                             slot_free,
  output logic                             busy,
  output logic                             fin,
  output logic [srps_pkg::STAT_W-1:0]      status,
  output logic [srps_pkg::LEN_W-1:0]       len,
  output srps_pkg::ram_ctrl_t              ram,
  output srps_pkg::dp_ctrl_t               dp
);

  srps_pkg::state_t                  state, state_next;
  srps_pkg::req_t                    kind, kind_next;
  logic [srps_pkg::LEN_W-1:0]        len_next;
  logic [srps_pkg::LEN_W-1:0]        cnt, cnt_next;
  logic [srps_pkg::ADDR_W-1:0]       rd_ptr, rd_ptr_next;
  logic [srps_pkg::ADDR_W-1:0]       p_addr, p_addr_next;
  logic                              p_vld, p_vld_next;
  logic [srps_pkg::ADDR_W-1:0]       ins_addr, ins_addr_next;
  logic [srps_pkg::STAT_W-1:0]       status_next;

  logic [srps_pkg::CMP_W-1:0] lo_c, hi_c, len_c, max_c;
  logic                       range_ok;

  assign lo_c     = srps_pkg::CMP_W'(first_position);
  assign hi_c     = srps_pkg::CMP_W'(last_position);
  assign len_c    = srps_pkg::CMP_W'(len);
  assign max_c    = srps_pkg::CMP_W'(srps_pkg::MAX_LEN);
  assign range_ok = (lo_c != '0) && (lo_c <= hi_c) && (hi_c <= len_c);

  // Next state, store accesses and datapath control
  always_comb begin
    state_next    = state;
    kind_next     = kind;
    len_next      = len;
    cnt_next      = cnt;
    rd_ptr_next   = rd_ptr;
    p_addr_next   = p_addr;
    p_vld_next    = p_vld;
    ins_addr_next = ins_addr;
    status_next   = status;
    ram           = '0;
    dp.init       = 1'b0;
    dp.op         = srps_pkg::DP_IDLE;
    dp.wd_sel     = srps_pkg::WD_VALUE;

    unique case (state)
      srps_pkg::S_IDLE: begin
        if (start) begin
          dp.init     = 1'b1;
          kind_next   = req;
          p_vld_next  = 1'b0;
          status_next = srps_pkg::ST_OK;
          if (req == srps_pkg::REQ_INSERT) begin
            ins_addr_next = srps_pkg::ADDR_W'(lo_c);
            if (lo_c > len_c) begin
              status_next = srps_pkg::ST_BAD_RANGE;
              state_next  = srps_pkg::S_FIN;
            end else if (len_c >= max_c) begin
              status_next = srps_pkg::ST_FULL;
              state_next  = srps_pkg::S_FIN;
            end else if (lo_c == len_c) begin
              state_next = srps_pkg::S_PLACE;
            end else begin
              cnt_next    = srps_pkg::LEN_W'(len_c - lo_c);
              rd_ptr_next = srps_pkg::ADDR_W'(len_c - 1'b1);
              state_next  = srps_pkg::S_SHIFT;
            end
          end else if (!range_ok) begin
            status_next = srps_pkg::ST_BAD_RANGE;
            state_next  = srps_pkg::S_FIN;
          end else begin
            cnt_next    = srps_pkg::LEN_W'(hi_c - lo_c + 1'b1);
            rd_ptr_next = srps_pkg::ADDR_W'(lo_c - 1'b1);
            state_next  = srps_pkg::S_WALK;
          end
        end
      end

      srps_pkg::S_WALK: begin
        if (kind == srps_pkg::REQ_ASSIGN) begin
          // Write straight through the range
          if (cnt != '0) begin
            ram.we      = 1'b1;
            ram.wr_addr = rd_ptr;
            rd_ptr_next = rd_ptr + 1'b1;
            cnt_next    = cnt - 1'b1;
          end else begin
            state_next = srps_pkg::S_FIN;
          end
        end else begin
          // Issue the next read
          if (cnt != '0) begin
            ram.rd_en   = 1'b1;
            ram.rd_addr = rd_ptr;
            p_addr_next = rd_ptr;
            p_vld_next  = 1'b1;
            rd_ptr_next = rd_ptr + 1'b1;
            cnt_next    = cnt - 1'b1;
          end else begin
            p_vld_next = 1'b0;
          end
          // Consume the element read last cycle
          if (p_vld) begin
            if (kind == srps_pkg::REQ_ADD) begin
              ram.we      = 1'b1;
              ram.wr_addr = p_addr;
              dp.op       = srps_pkg::DP_ADD;
              dp.wd_sel   = srps_pkg::WD_SUM;
            end else begin
              dp.op = srps_pkg::DP_SUM;
            end
          end
          if (cnt == '0 && !p_vld) begin
            state_next = srps_pkg::S_FIN;
          end
        end
      end

      srps_pkg::S_SHIFT: begin
        // Move elements up by one, from the tail down
        if (cnt != '0) begin
          ram.rd_en   = 1'b1;
          ram.rd_addr = rd_ptr;
          p_addr_next = rd_ptr + 1'b1;
          p_vld_next  = 1'b1;
          rd_ptr_next = rd_ptr - 1'b1;
          cnt_next    = cnt - 1'b1;
        end else begin
          p_vld_next = 1'b0;
        end
        if (p_vld) begin
          ram.we      = 1'b1;
          ram.wr_addr = p_addr;
          dp.wd_sel   = srps_pkg::WD_COPY;
        end
        if (cnt == '0 && !p_vld) begin
          state_next = srps_pkg::S_PLACE;
        end
      end

      srps_pkg::S_PLACE: begin
        ram.we      = 1'b1;
        ram.wr_addr = ins_addr;
        len_next    = len + 1'b1;
        state_next  = srps_pkg::S_FIN;
      end

      srps_pkg::S_FIN: begin
        if (slot_free) begin
          state_next = srps_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = srps_pkg::S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srps_pkg::S_IDLE;
      len   <= '0;
      p_vld <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      p_vld <= p_vld_next;
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    kind     <= kind_next;
    cnt      <= cnt_next;
    rd_ptr   <= rd_ptr_next;
    p_addr   <= p_addr_next;
    ins_addr <= ins_addr_next;
    status   <= status_next;
  end

  assign busy = (state != srps_pkg::S_IDLE);
  assign fin  = (state == srps_pkg::S_FIN);

endmodule

// ===== hw/rtl/sequence_range_progression_sum_unit.sv =====
// An ordered sequence of up to MAX_LEN (1024) signed 64-bit values held in one
// memory, with range assign, range progression add, insert and range sum. One
// request is worked at a time and yields one result (status plus range_sum).
// A request walks its elements through the single memory port pair at one
// element per cycle. A finished result waits in an output register, so the
// next request is taken while it is still pending. Depends on srps_pkg,
// srps_ram, srps_dp and srps_ctrl.
module sequence_range_progression_sum_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         req_type,
  input  logic [srps_pkg::POS_W-1:0]         first_position,
  input  logic [srps_pkg::POS_W-1:0]         last_position,
  input  logic signed [srps_pkg::OPER_W-1:0] operand_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [srps_pkg::STAT_W-1:0]        status,
  output logic signed [srps_pkg::DATA_W-1:0] range_sum
);

  logic                              start;
  logic                              busy;
  logic                              fin;
  logic                              slot_free;
  logic [srps_pkg::STAT_W-1:0]       fin_status;
  logic [srps_pkg::LEN_W-1:0]        len;
  srps_pkg::ram_ctrl_t               ram;
  srps_pkg::dp_ctrl_t                dp;
  logic [srps_pkg::DATA_W-1:0]       rd_data;
  logic [srps_pkg::DATA_W-1:0]       wr_data;
  logic signed [srps_pkg::DATA_W-1:0] acc_sum;

  // Input transfer only while idle
  assign in_stall  = busy;
  assign start     = in_valid && !busy;
  assign slot_free = !out_valid || !out_stall;

  srps_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .req            (srps_pkg::req_t'(req_type)),
    .first_position (first_position),
    .last_position  (last_position),
    .slot_free      (slot_free),
    .busy           (busy),
    .fin            (fin),
    .status         (fin_status),
    .len            (len),
    .ram            (ram),
    .dp             (dp)
  );

  srps_dp u_dp (
    .clk           (clk),
    .ctl           (dp),
    .operand_value (operand_value),
    .rd_data       (rd_data),
    .wr_data       (wr_data),
    .range_sum     (acc_sum)
  );

  srps_ram #(
    .WIDTH (srps_pkg::DATA_W),
    .DEPTH (srps_pkg::MAX_LEN)
  ) u_store (
    .clk     (clk),
    .we      (ram.we),
    .wr_addr (ram.wr_addr),
    .wr_data (wr_data),
    .rd_en   (ram.rd_en),
    .rd_addr (ram.rd_addr),
    .rd_data (rd_data)
  );

  // Output valid: set when a result is loaded, drop after its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the result payload until it is taken
  always_ff @(posedge clk) begin
    if (fin && slot_free) begin
      status    <= fin_status;
      range_sum <= acc_sum;
    end
  end

  // The walk never reads and writes the same entry in one cycle
  a_no_collision: assert property (@(posedge clk) disable iff (rst)
    (ram.we && ram.rd_en) |-> (ram.wr_addr != ram.rd_addr))
    else $error("store read and write collide");

  // The sequence never grows past the store
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= srps_pkg::LEN_W'(srps_pkg::MAX_LEN))
    else $error("sequence length exceeds store");

  // Rejected requests report a zero sum
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != srps_pkg::ST_OK) |-> (range_sum == '0))
    else $error("rejected request carries a sum");

  // A loaded result shows up as valid next cycle
  a_result_valid: assert property (@(posedge clk) disable iff (rst)
    (fin && slot_free) |=> out_valid)
    else $error("finished result not presented");

endmodule
